// ===== rtl/ems_pkg.sv =====
// Package for the edge midpoint subdivider: widths, microcode types and the control ROM.
// Used by every module of the block; has no dependencies of its own.
`default_nettype none

package ems_pkg;

  // Field widths and fixed-point layout
  localparam int COORD_W     = 16;                  // Q8.8 input coordinate
  localparam int EXTRA_FRAC  = 6;                   // extra fraction bits on output points
  localparam int POINT_W     = 22;                  // output point, units of 2^-14
  localparam int DELTA_W     = 35;                  // threshold register
  localparam int MAX_DEPTH   = 6;                   // deepest halving level
  localparam int DIFF_W      = COORD_W + 1;         // signed edge difference
  localparam int SQ_W        = 2 * COORD_W;         // one squared difference
  localparam int SUM_W       = SQ_W + 1;            // sum of squares
  localparam int THR_W       = DELTA_W + 2 * MAX_DEPTH;
  localparam int DEPTH_W     = $clog2(MAX_DEPTH + 1);
  localparam int CNT_W       = MAX_DEPTH + 1;       // holds 2^MAX_DEPTH
  localparam int SHIFT_W     = $clog2(EXTRA_FRAC + 1);

  localparam logic [DELTA_W-1:0] DELTA_RESET = DELTA_W'(4096);

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_LOAD,
    OP_DIFF,
    OP_SQX,
    OP_SQY,
    OP_INIT,
    OP_TEST,
    OP_CAP,
    OP_DEEPEN,
    OP_SETUP,
    OP_EMIT
  } op_e;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_IN_FIRE,
    COND_FIT,
    COND_KMAX,
    COND_LAST_FIRE
  } cond_e;

  // Program addresses
  localparam int NUM_STEPS = 10;
  localparam int STEP_W    = $clog2(NUM_STEPS);

  localparam logic [STEP_W-1:0] STEP_LOAD   = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_DIFF   = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_SQX    = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_SQY    = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_INIT   = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_TEST   = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_CAP    = STEP_W'(6);
  localparam logic [STEP_W-1:0] STEP_DEEPEN = STEP_W'(7);
  localparam logic [STEP_W-1:0] STEP_SETUP  = STEP_W'(8);
  localparam logic [STEP_W-1:0] STEP_EMIT   = STEP_W'(9);

  // Control word: operation, then jump to target if cond holds,
  // else stay when hold is set, else fall through.
  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic              hold;
    logic [STEP_W-1:0] target;
  } ctl_t;

  // Datapath status back to the sequencer
  typedef struct packed {
    logic in_fire;
    logic out_fire;
    logic fit;
    logic kmax;
    logic last;
  } stat_t;

  function automatic ctl_t ems_rom(input logic [STEP_W-1:0] step);
    ctl_t w;
    unique case (step)
      STEP_LOAD:   w = '{OP_LOAD,   COND_IN_FIRE,   1'b1, STEP_DIFF};
      STEP_DIFF:   w = '{OP_DIFF,   COND_NEVER,     1'b0, STEP_LOAD};
      STEP_SQX:    w = '{OP_SQX,    COND_NEVER,     1'b0, STEP_LOAD};
      STEP_SQY:    w = '{OP_SQY,    COND_NEVER,     1'b0, STEP_LOAD};
      STEP_INIT:   w = '{OP_INIT,   COND_NEVER,     1'b0, STEP_LOAD};
      STEP_TEST:   w = '{OP_TEST,   COND_FIT,       1'b0, STEP_SETUP};
      STEP_CAP:    w = '{OP_CAP,    COND_KMAX,      1'b0, STEP_SETUP};
      STEP_DEEPEN: w = '{OP_DEEPEN, COND_ALWAYS,    1'b0, STEP_TEST};
      STEP_SETUP:  w = '{OP_SETUP,  COND_NEVER,     1'b0, STEP_LOAD};
      STEP_EMIT:   w = '{OP_EMIT,   COND_LAST_FIRE, 1'b1, STEP_LOAD};
      default:     w = '{OP_LOAD,   COND_ALWAYS,    1'b0, STEP_LOAD};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ems_edge_if.sv =====
// Input channel interface: one edge per transaction.
// Depends on ems_pkg for the coordinate width.
`default_nettype none

interface ems_edge_if
  import ems_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/ems_point_if.sv =====
// Output channel interface: one subdivision point per transaction.
// Depends on ems_pkg for the point width.
`default_nettype none

interface ems_point_if
  import ems_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [POINT_W-1:0] point_x;
  logic signed [POINT_W-1:0] point_y;
  logic                      last_point;
  logic                      depth_capped;

  modport source (output valid, point_x, point_y, last_point, depth_capped, input ready);
  modport sink   (input valid, point_x, point_y, last_point, depth_capped, output ready);
endinterface

`default_nettype wire

// ===== rtl/ems_sequencer.sv =====
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on ems_pkg (ctl_t, stat_t, ems_rom).
`default_nettype none

module ems_sequencer
  import ems_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire stat_t stat_i,
  output ctl_t       ctl_o
);

  logic [STEP_W-1:0] pc_q, pc_d;
  logic              take;

  assign ctl_o = ems_rom(pc_q);

  always_comb begin
    unique case (ctl_o.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_IN_FIRE:   take = stat_i.in_fire;
      COND_FIT:       take = stat_i.fit;
      COND_KMAX:      take = stat_i.kmax;
      COND_LAST_FIRE: take = stat_i.out_fire & stat_i.last;
      default:        take = 1'b1;
    endcase

    if (take) begin
      pc_d = ctl_o.target;
    end else if (ctl_o.hold) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_LOAD;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ems_datapath.sv =====
// Datapath: edge registers, shared squarer, depth search and point accumulator.
// Driven one control word per cycle by ems_sequencer; depends on ems_pkg.
`default_nettype none

module ems_datapath
  import ems_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire ctl_t                      ctl_i,
  output stat_t                          stat_o,
  // configuration
  input  wire logic                      cfg_we_i,
  input  wire logic [DELTA_W-1:0]        cfg_wdata_i,
  // edge in
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic signed [COORD_W-1:0] start_x_i,
  input  wire logic signed [COORD_W-1:0] start_y_i,
  input  wire logic signed [COORD_W-1:0] end_x_i,
  input  wire logic signed [COORD_W-1:0] end_y_i,
  // point out
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic signed [POINT_W-1:0]      point_x_o,
  output logic signed [POINT_W-1:0]      point_y_o,
  output logic                           last_point_o,
  output logic                           depth_capped_o
);

  logic [DELTA_W-1:0]        delta_q;
  logic signed [COORD_W-1:0] sx_q, sy_q, ex_q, ey_q;
  logic signed [DIFF_W-1:0]  dx_q, dy_q;
  logic [COORD_W-1:0]        ax_q, ay_q;
  logic [SQ_W-1:0]           sqx_q, sqy_q;
  logic [SUM_W-1:0]          sum_q;
  logic [THR_W-1:0]          thr_q;
  logic [DEPTH_W-1:0]        k_q;
  logic                      cap_q;
  logic signed [POINT_W-1:0] px_q, py_q, stx_q, sty_q;
  logic [CNT_W-1:0]          cnt_q;

  logic                      in_fire, out_fire;
  logic [SHIFT_W-1:0]        sh;
  logic signed [POINT_W-1:0] stx_d, sty_d;
  logic [COORD_W-1:0]        sq_arg;

  assign in_ready_o  = (ctl_i.op == OP_LOAD);
  assign out_valid_o = (ctl_i.op == OP_EMIT);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_fire    = out_valid_o & out_ready_i;

  assign stat_o.in_fire  = in_fire;
  assign stat_o.out_fire = out_fire;
  assign stat_o.fit      = (THR_W'(sum_q) <= thr_q);
  assign stat_o.kmax     = (k_q == DEPTH_W'(MAX_DEPTH));
  assign stat_o.last     = (cnt_q == CNT_W'(1));

  assign point_x_o      = px_q;
  assign point_y_o      = py_q;
  assign last_point_o   = (cnt_q == CNT_W'(1));
  assign depth_capped_o = cap_q;

  // Piece step: difference scaled to 2^-14 units for depth k
  assign sh    = SHIFT_W'(EXTRA_FRAC) - SHIFT_W'(k_q);
  assign stx_d = POINT_W'(dx_q) <<< sh;
  assign sty_d = POINT_W'(dy_q) <<< sh;

  // One squarer shared by the x and y steps
  assign sq_arg = (ctl_i.op == OP_SQX) ? ax_q : ay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q <= DELTA_RESET;
    end else if (cfg_we_i) begin
      delta_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 1'b0;
      cnt_q <= '0;
      k_q   <= '0;
    end else begin
      unique case (ctl_i.op)
        OP_INIT: begin
          cap_q <= 1'b0;
          k_q   <= '0;
        end
        OP_CAP:    cap_q <= stat_o.kmax;
        OP_DEEPEN: k_q   <= k_q + DEPTH_W'(1);
        OP_SETUP:  cnt_q <= CNT_W'(1) << k_q;
        OP_EMIT: begin
          if (out_fire) begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      OP_LOAD: begin
        if (in_fire) begin
          sx_q <= start_x_i;
          sy_q <= start_y_i;
          ex_q <= end_x_i;
          ey_q <= end_y_i;
        end
      end
      OP_DIFF: begin
        dx_q <= DIFF_W'(ex_q) - DIFF_W'(sx_q);
        dy_q <= DIFF_W'(ey_q) - DIFF_W'(sy_q);
        ax_q <= (ex_q >= sx_q) ? COORD_W'(ex_q - sx_q) : COORD_W'(sx_q - ex_q);
        ay_q <= (ey_q >= sy_q) ? COORD_W'(ey_q - sy_q) : COORD_W'(sy_q - ey_q);
      end
      OP_SQX: sqx_q <= SQ_W'(sq_arg) * SQ_W'(sq_arg);
      OP_SQY: sqy_q <= SQ_W'(sq_arg) * SQ_W'(sq_arg);
      OP_INIT: begin
        sum_q <= SUM_W'(sqx_q) + SUM_W'(sqy_q);
        thr_q <= THR_W'(delta_q);
      end
      OP_DEEPEN: thr_q <= thr_q << 2;
      OP_SETUP: begin
        stx_q <= stx_d;
        sty_q <= sty_d;
        px_q  <= (POINT_W'(sx_q) <<< EXTRA_FRAC) + stx_d;
        py_q  <= (POINT_W'(sy_q) <<< EXTRA_FRAC) + sty_d;
      end
      OP_EMIT: begin
        if (out_fire) begin
          px_q <= px_q + stx_q;
          py_q <= py_q + sty_q;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/edge_midpoint_subdivider.sv =====
// Edge midpoint subdivider, top level: sequencer plus datapath.
// Depends on ems_pkg, ems_edge_if, ems_point_if, ems_sequencer, ems_datapath.
// Usage
//   edge_i takes one edge per transaction (start and end point, signed Q8.8).
//   point_o returns 2^k points per edge, from just after the start point to
//   the end point, in units of 2^-14; last_point marks the end point and
//   depth_capped is set on every point of an edge still too long at the
//   deepest level. cfg_we_i/cfg_wdata_i write delta_squared unguarded; the
//   user must write only while no edge is in progress (edge_i.ready high).
// Timing
//   One edge at a time: an accept step; difference, x square, y square and
//   sum (one shared squarer); test, cap check and deepen per halving level
//   tried; a final test (and a cap check when capped); setup; then one point
//   per cycle while point_o.ready is high.
// Reset
//   Asynchronous, active low: sequencer back to its accept step and
//   delta_squared to 4096 (0.25 squared).
// Back-pressure
//   While point_o.ready is low the current point holds and the sequencer
//   waits; no new edge is taken until the last point is delivered.
`default_nettype none

module edge_midpoint_subdivider
  import ems_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [DELTA_W-1:0] cfg_wdata_i,
  ems_edge_if.sink                edge_i,
  ems_point_if.source             point_o
);

  ctl_t  ctl;
  stat_t stat;

  // Control: program counter walks the ROM
  ems_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  // Arithmetic and handshake decode
  ems_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (edge_i.valid),
    .in_ready_o     (edge_i.ready),
    .start_x_i      (edge_i.start_x),
    .start_y_i      (edge_i.start_y),
    .end_x_i        (edge_i.end_x),
    .end_y_i        (edge_i.end_y),
    .out_valid_o    (point_o.valid),
    .out_ready_i    (point_o.ready),
    .point_x_o      (point_o.point_x),
    .point_y_o      (point_o.point_y),
    .last_point_o   (point_o.last_point),
    .depth_capped_o (point_o.depth_capped)
  );

endmodule

`default_nettype wire

// ===== rtl/ems_checker.sv =====
// Port-level assertions for the edge midpoint subdivider, and the bind to the top level.
// Depends on ems_pkg for field widths.
`default_nettype none

module ems_checker
  import ems_pkg::*;
(
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_i,
  input wire logic                      out_valid_i,
  input wire logic                      out_ready_i,
  input wire logic signed [POINT_W-1:0] point_x_i,
  input wire logic signed [POINT_W-1:0] point_y_i,
  input wire logic                      last_point_i,
  input wire logic                      depth_capped_i
);

  // No edge taken while a point is on offer
  a_no_accept_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("edge accepted while a point is pending");

  // Stalled point holds
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(point_x_i) && $stable(point_y_i) && $stable(last_point_i)))
    else $error("point changed while stalled");

  // Edge run ends on last point
  a_end_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && last_point_i) |=> !out_valid_i)
    else $error("points continued after the last point");

  // Run continues with same cap flag
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !last_point_i) |=> (out_valid_i && $stable(depth_capped_i)))
    else $error("edge run broken or cap flag changed");

  // Accepting an edge starts the sequence
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> (!in_ready_i && !out_valid_i))
    else $error("not busy after accepting an edge");

endmodule

bind edge_midpoint_subdivider ems_checker u_ems_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (edge_i.valid),
  .in_ready_i     (edge_i.ready),
  .out_valid_i    (point_o.valid),
  .out_ready_i    (point_o.ready),
  .point_x_i      (point_o.point_x),
  .point_y_i      (point_o.point_y),
  .last_point_i   (point_o.last_point),
  .depth_capped_i (point_o.depth_capped)
);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking bench for edge_midpoint_subdivider: directed table, then random phases.
// Depends on ems_pkg, ems_edge_if, ems_point_if and the block's RTL.
`default_nettype none

module tb
  import ems_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF        = 10;
  localparam int RESET_CYCLES    = 6;
  localparam int DIR_ROWS        = 20;
  localparam int RAND_PHASES     = 6;
  localparam int EDGES_PER_PHASE = 60;
  localparam int TAIL_CYCLES     = 120;
  // Longest quiet stretch of a correct run: a capped edge's way to its first
  // point, plus the longest receiver stall behind each point and the longest
  // sender pause. The limit is that sum many times over.
  localparam int WATCHDOG_LIMIT  = 4000;

  // One subdivision point, laid out as the point channel carries it
  typedef struct packed {
    logic signed [POINT_W-1:0] x;
    logic signed [POINT_W-1:0] y;
    logic                      last;
    logic                      capped;
  } point_t;

  // One directed row: threshold to run under, the edge, and an optional
  // hand-typed single point (only for depth-0 edges)
  typedef struct packed {
    logic [DELTA_W-1:0]        delta;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic                      typed;
    point_t                    want;
  } edge_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [DELTA_W-1:0] cfg_wdata_i;

  ems_edge_if  edge_if ();
  ems_point_if point_if ();

  edge_midpoint_subdivider i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .edge_i      (edge_if),
    .point_o     (point_if)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Bench copy of the threshold register, followed at the write edge
  logic [DELTA_W-1:0] threshold_now;
  // Value last written by the stimulus side, used to decide when to rewrite
  logic [DELTA_W-1:0] threshold_set;
  // Points still owed by the block, oldest first
  point_t             pending_points[$];
  // Hand-typed expectation travelling with the edge currently on the bus
  logic               row_typed;
  point_t             row_want;
  // Set for phases that run both sides flat out
  bit                 no_idle;
  int                 mismatches;
  int                 quiet_cycles;

  edge_row_t dir_rows [DIR_ROWS];

  // Append one owed point at the young end of the queue
  function automatic void owe_point(input point_t p);
    pending_points = {pending_points, p};
  endfunction

  // Work out every point the block owes for one edge and queue them.
  // The smallest depth k whose pieces fit is chosen by comparing the squared
  // edge length against threshold * 4^k; beyond MAX_DEPTH the edge is capped.
  function automatic void subdivide_edge(input logic signed [COORD_W-1:0] sx, sy, ex, ey);
    longint          dx, dy, bx, by, stx, sty;
    longint unsigned len_sq;
    logic [63:0]     limit, px, py;
    int              depth, k, n, i;
    bit              capped;
    point_t          p;
    dx     = longint'(ex) - longint'(sx);
    dy     = longint'(ey) - longint'(sy);
    len_sq = dx * dx + dy * dy;
    capped = 1'b1;
    depth  = MAX_DEPTH;
    for (k = 0; k <= MAX_DEPTH; k++) begin
      limit = {{(64 - DELTA_W){1'b0}}, threshold_now} << (2 * k);
      if (capped && len_sq <= limit) begin
        capped = 1'b0;
        depth  = k;
      end
    end
    bx  = longint'(sx) <<< EXTRA_FRAC;
    by  = longint'(sy) <<< EXTRA_FRAC;
    stx = dx <<< (EXTRA_FRAC - depth);
    sty = dy <<< (EXTRA_FRAC - depth);
    n   = 1 << depth;
    for (i = 1; i <= n; i++) begin
      px       = bx + longint'(i) * stx;
      py       = by + longint'(i) * sty;
      p.x      = px[POINT_W-1:0];
      p.y      = py[POINT_W-1:0];
      p.last   = (i == n);
      p.capped = capped;
      owe_point(p);
    end
  endfunction

  // Idle length: mostly very short, sometimes a handful, rarely long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 2);
    end else if (r < 95) begin
      return $urandom_range(3, 6);
    end
    return $urandom_range(10, 30);
  endfunction

  // Signed offset drawn from [-2^m, 2^m]
  function automatic int rand_offset(input int m);
    int span;
    span = 1 << m;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Threshold for a random phase: the extremes, the reset value or one now and then;
  // otherwise a value of random magnitude so that the depth spreads over 0..MAX_DEPTH
  function automatic logic [DELTA_W-1:0] rand_threshold();
    logic [63:0] raw, mask;
    raw  = {$urandom, $urandom};
    mask = (64'd1 << $urandom_range(0, DELTA_W)) - 64'd1;
    case ($urandom_range(0, 7))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      2: begin
        return DELTA_RESET;
      end
      3: begin
        return DELTA_W'(1);
      end
      default: begin
        return DELTA_W'(raw & mask);
      end
    endcase
  endfunction

  // Offer one edge transaction after an optional gap and hold it until taken.
  // Valid stays high into the next edge when there is no gap.
  task automatic send_edge(input logic signed [COORD_W-1:0] sx, sy, ex, ey,
                           input logic typed, input point_t want);
    int gap;
    gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    repeat (gap) begin
      @(negedge clk_i);
      edge_if.valid = 1'b0;
    end
    @(negedge clk_i);
    edge_if.start_x = sx;
    edge_if.start_y = sy;
    edge_if.end_x   = ex;
    edge_if.end_y   = ey;
    row_typed       = typed;
    row_want        = want;
    edge_if.valid   = 1'b1;
    do begin
      @(posedge clk_i);
    end while (!edge_if.ready);
  endtask

  // Stop offering edges and wait until every owed point has come back and
  // the block is ready for a new edge again.
  task automatic drain();
    @(negedge clk_i);
    edge_if.valid = 1'b0;
    while (pending_points.size() != 0) begin
      @(posedge clk_i);
    end
    while (!edge_if.ready) begin
      @(posedge clk_i);
    end
  endtask

  // Threshold writes happen only with the block idle
  task automatic write_threshold(input logic [DELTA_W-1:0] value);
    drain();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    threshold_set = value;
  endtask

  // Random edge: mostly an end point a random distance from the start, with
  // a few degenerate edges and a few with both ends anywhere
  task automatic send_random_edge();
    logic signed [COORD_W-1:0] sx, sy, ex, ey;
    int m;
    sx = COORD_W'($urandom);
    sy = COORD_W'($urandom);
    case ($urandom_range(0, 15))
      0: begin
        ex = sx;
        ey = sy;
      end
      1: begin
        ex = COORD_W'($urandom);
        ey = COORD_W'($urandom);
      end
      default: begin
        m  = $urandom_range(0, COORD_W - 1);
        ex = COORD_W'(int'(sx) + rand_offset(m));
        ey = COORD_W'(int'(sy) + rand_offset($urandom_range(0, m)));
      end
    endcase
    send_edge(sx, sy, ex, ey, 1'b0, '0);
  endtask

  // Receiver: ready drops for random stretches unless a flat-out phase runs
  initial begin : point_sink
    int stall_left;
    stall_left     = 0;
    point_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        point_if.ready = 1'b0;
        stall_left--;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        point_if.ready = 1'b0;
        stall_left     = idle_len() - 1;
      end else begin
        point_if.ready = 1'b1;
      end
    end
  end

  // Scoreboard: follows threshold writes, predicts on every accepted edge,
  // checks every accepted point against the oldest owed one, and keeps the
  // watchdog on transactions on either channel.
  always @(posedge clk_i) begin : scoreboard
    point_t got, want;
    logic   moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_we_i) begin
        threshold_now = cfg_wdata_i;
      end
      if (edge_if.valid && edge_if.ready) begin
        moved = 1'b1;
        if (row_typed) begin
          owe_point(row_want);
        end else begin
          subdivide_edge(edge_if.start_x, edge_if.start_y, edge_if.end_x, edge_if.end_y);
        end
      end
      if (point_if.valid && point_if.ready) begin
        moved = 1'b1;
        got   = '{point_if.point_x, point_if.point_y, point_if.last_point,
                  point_if.depth_capped};
        if (pending_points.size() == 0) begin
          mismatches++;
          $display("%0t: point with none owed: x=%0d y=%0d last=%0b capped=%0b",
                   $time, got.x, got.y, got.last, got.capped);
        end else begin
          want = pending_points.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: point mismatch: expected x=%0d y=%0d last=%0b capped=%0b",
                     $time, want.x, want.y, want.last, want.capped);
            $display("%0t:                 actual   x=%0d y=%0d last=%0b capped=%0b",
                     $time, got.x, got.y, got.last, got.capped);
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int r, ph, n;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    edge_if.valid   = 1'b0;
    edge_if.start_x = '0;
    edge_if.start_y = '0;
    edge_if.end_x   = '0;
    edge_if.end_y   = '0;
    row_typed       = 1'b0;
    row_want        = '0;
    no_idle         = 1'b0;
    mismatches      = 0;
    quiet_cycles    = 0;
    threshold_now   = DELTA_RESET;
    threshold_set   = DELTA_RESET;

    // Directed rows. Fields: threshold, start x/y, end x/y, typed, point.
    dir_rows = '{
      // reset threshold: degenerate edges, exact boundary, one step past it
      '{DELTA_RESET, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1,
        '{22'sd0, 22'sd0, 1'b1, 1'b0}},
      '{DELTA_RESET, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b1,
        '{22'h200000, 22'h1FFFC0, 1'b1, 1'b0}},
      '{DELTA_RESET, 16'sd0, 16'sd0, 16'sd64, 16'sd0, 1'b1,
        '{22'sd4096, 22'sd0, 1'b1, 1'b0}},
      '{DELTA_RESET, 16'sd0, 16'sd0, 16'sd65, 16'sd0, 1'b0, '0},
      // full-span diagonals, both directions: capped; then a shorter, uncapped edge
      '{DELTA_RESET, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b0, '0},
      '{DELTA_RESET, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b0, '0},
      '{DELTA_RESET, 16'sd100, -16'sd200, -16'sd300, 16'sd50, 1'b0, '0},
      // zero threshold: only a degenerate edge fits, everything else caps
      '{35'd0, 16'sd1234, -16'sd5678, 16'sd1234, -16'sd5678, 1'b1,
        '{22'sd78976, -22'sd363392, 1'b1, 1'b0}},
      '{35'd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 1'b0, '0},
      '{35'd0, -16'sd1, -16'sd1, 16'sd0, 16'sd0, 1'b0, '0},
      // all-ones threshold: every edge is a single piece
      '{35'h7_FFFF_FFFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b1,
        '{22'h1FFFC0, 22'h1FFFC0, 1'b1, 1'b0}},
      '{35'h7_FFFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b1,
        '{22'h200000, 22'h200000, 1'b1, 1'b0}},
      // threshold of one: depth follows edge length step by step
      '{35'd1, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 1'b1,
        '{22'sd64, 22'sd0, 1'b1, 1'b0}},
      '{35'd1, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 1'b0, '0},
      '{35'd1, 16'sd0, 16'sd0, 16'sd0, -16'sd8, 1'b0, '0},
      '{35'd1, 16'sd0, 16'sd0, 16'sd0, -16'sd9, 1'b0, '0},
      // top bit of the register set alone (2^34)
      '{35'h4_0000_0000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b1,
        '{22'h1FFFC0, 22'h1FFFC0, 1'b1, 1'b0}},
      '{35'h4_0000_0000, -16'sd12345, 16'sd23456, 16'sd54, -16'sd999, 1'b0, '0},
      // back to reset value: exactly deepest level, then one past the cap
      '{DELTA_RESET, 16'sd0, 16'sd0, 16'sd4096, 16'sd0, 1'b0, '0},
      '{DELTA_RESET, 16'sd0, 16'sd0, 16'sd4097, 16'sd0, 1'b0, '0}
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].delta != threshold_set) begin
        write_threshold(dir_rows[r].delta);
      end
      send_edge(dir_rows[r].sx, dir_rows[r].sy, dir_rows[r].ex, dir_rows[r].ey,
                dir_rows[r].typed, dir_rows[r].want);
    end

    // Random phases, each under a fresh threshold; one runs without idling
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      write_threshold(rand_threshold());
      no_idle = (ph == 2);
      for (n = 0; n < EDGES_PER_PHASE; n++) begin
        send_random_edge();
      end
    end

    drain();
    no_idle = 1'b0;
    // Stray points after the last owed one are caught here
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
